@@ hdl/wzn_pkg.sv @@
// wzn_pkg: shared constants, types and state encoding for the z-score normalizer
// no dependencies
`timescale 1ns / 1ps
package wzn_pkg;
   localparam int MAX_SAMPLES = 64;
   localparam int IDX_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

   // divider jobs
   localparam logic [1:0] DIV_MEAN = 2'd0;
   localparam logic [1:0] DIV_VAR  = 2'd1;
   localparam logic [1:0] DIV_NORM = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_DIV,
      ST_LD_MUL,
      ST_LD_WAIT,
      ST_LD_PROD,
      ST_LD_ACC,
      ST_SD_DIV,
      ST_SD_SQRT,
      ST_RD,
      ST_NM_DIV,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture input item
      logic store_wr;    // write sample store
      logic div_start;   // start divider
      logic mul_step;    // form deviation products
      logic acc;         // accumulate sums
      logic sqrt_start;  // start root
      logic rd;          // read sample store
      logic clr;         // clear run state
      logic [1:0] sel;   // divider job
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic sqrt_done;
      logic full;
      logic fin;
      logic empty;
      logic last;
   } sts_type;
endpackage

@@ hdl/welford_zscore_normalizer.sv @@
// welford_zscore_normalizer: top level, controller plus datapath
// depends on wzn_pkg, wzn_control, wzn_datapath
// load: one input transfer at a time; a kept sample holds off the next through the 64-step serial mean divide
// final sample: rsp_valid follows its mean step (skipped when it is dropped), then the
//    variance divide plus 32-step root; then one result per norm divide, each held until taken
// synchronous active-high reset returns to idle with the run statistics cleared
`timescale 1ns / 1ps
module welford_zscore_normalizer import wzn_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_feature_a,
   input  logic signed [15:0] req_feature_b,
   input  logic req_final_sample,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [15:0] rsp_norm_a,
   output logic signed [15:0] rsp_norm_b,
   output logic [5:0] rsp_sample_index,
   output logic [15:0] rsp_deviation_a,
   output logic [1:0] rsp_zero_spread,
   output logic rsp_overflowed,
   output logic rsp_end_of_run
);
   cmd_type cmd;
   sts_type sts;
   logic [IDX_W-1:0] idx;
   wzn_control u_ctl (.clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd);
   wzn_datapath u_dp (.clock, .reset, .cmd, .sts, .req_feature_a, .req_feature_b,
      .req_final_sample, .norm_a(rsp_norm_a), .norm_b(rsp_norm_b), .idx,
      .dev_a(rsp_deviation_a), .zs(rsp_zero_spread), .ovf(rsp_overflowed));
   assign rsp_sample_index = 6'(idx);
   assign rsp_end_of_run = sts.last;

   // input and result sides never open together
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid));
   // a waiting result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_norm_a, rsp_norm_b,
      rsp_sample_index, rsp_deviation_a, rsp_zero_spread, rsp_overflowed, rsp_end_of_run}));
   // reset leaves the block idle and ready
   a_reset_idle: assert property (@(posedge clock) reset |=> req_ready && !rsp_valid);
endmodule

@@ hdl/wzn_datapath.sv @@
// wzn_datapath: sample store, welford statistics, serial divider and root
// depends on wzn_pkg
`timescale 1ns / 1ps
module wzn_datapath import wzn_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  logic signed [15:0] req_feature_a,
   input  logic signed [15:0] req_feature_b,
   input  logic req_final_sample,
   output logic signed [15:0] norm_a,
   output logic signed [15:0] norm_b,
   output logic [IDX_W-1:0] idx,
   output logic [15:0] dev_a,
   output logic [1:0] zs,
   output logic ovf
);
   logic [31:0] mem [MAX_SAMPLES];
   logic [31:0] rd_ff;
   logic signed [15:0] xa_ff, xb_ff;
   logic fin_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [IDX_W-1:0] rix_ff;
   logic drop_ff;
   logic signed [31:0] ma_ff, mb_ff;
   logic [47:0] sa_ff, sb_ff;
   logic signed [31:0] da_ff, db_ff;
   logic [63:0] pa_ff, pb_ff;
   logic [31:0] stda_ff, stdb_ff;

   // two-lane restoring divider, one quotient bit a cycle over 64 bits
   logic [63:0] dna_ff, dnb_ff, qa_ff, qb_ff;
   logic [63:0] ra_ff, rb_ff;
   logic [31:0] dvra_ff, dvrb_ff;
   logic [6:0] dc_ff;
   logic dbusy_ff;
   logic [64:0] tra, trb;
   assign tra = {ra_ff, dna_ff[63]} - {33'd0, dvra_ff};
   assign trb = {rb_ff, dnb_ff[63]} - {33'd0, dvrb_ff};

   // root: two lanes, one result bit a cycle over 64-bit radicand
   logic [63:0] va_ff, vb_ff, rta_ff, rtb_ff, bit_ff;
   logic sbusy_ff;

   logic signed [32:0] ea, eb, na, nb;
   logic [31:0] absa, absb;
   assign ea = 33'(32'(xa_ff) * 256) - 33'(ma_ff);
   assign eb = 33'(32'(xb_ff) * 256) - 33'(mb_ff);
   assign absa = ea[32] ? 32'(-ea) : 32'(ea);
   assign absb = eb[32] ? 32'(-eb) : 32'(eb);
   assign na = 33'(32'(signed'(rd_ff[15:0])) * 256) - 33'(ma_ff);
   assign nb = 33'(32'(signed'(rd_ff[31:16])) * 256) - 33'(mb_ff);

   // mean step: quotient of |d| / n applied with the sign of d
   logic [1:0] sel_ff;
   logic signed [32:0] mna, mnb;
   always_ff @(posedge clock) begin
      if (cmd.div_start) sel_ff <= cmd.sel;
   end
   assign mna = 33'(ma_ff) + (da_ff[31] ? -33'(qa_ff[31:0]) : 33'(qa_ff[31:0]));
   assign mnb = 33'(mb_ff) + (db_ff[31] ? -33'(qb_ff[31:0]) : 33'(qb_ff[31:0]));

   always_ff @(posedge clock) begin
      if (cmd.store_wr) mem[cnt_ff[IDX_W-1:0]] <= {xb_ff, xa_ff};
      if (cmd.rd) rd_ff <= mem[rix_ff];
      if (cmd.load) begin
         xa_ff <= req_feature_a;
         xb_ff <= req_feature_b;
         fin_ff <= req_final_sample;
      end
      if (cmd.mul_step) begin
         pa_ff <= 64'(absa) * 64'(da_ff[31] ? -da_ff : da_ff);
         pb_ff <= 64'(absb) * 64'(db_ff[31] ? -db_ff : db_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr) begin
         cnt_ff <= '0;
         drop_ff <= 1'b0;
         ma_ff <= '0;
         mb_ff <= '0;
         sa_ff <= '0;
         sb_ff <= '0;
         rix_ff <= '0;
      end else begin
         if (cmd.load && cnt_ff == CNT_W'(MAX_SAMPLES)) drop_ff <= 1'b1;
         if (cmd.store_wr) begin
            cnt_ff <= cnt_ff + 1'b1;
            da_ff <= 32'(ea);
            db_ff <= 32'(eb);
         end
         if (sts.div_done && sel_ff == DIV_MEAN) begin
            ma_ff <= 32'(mna);
            mb_ff <= 32'(mnb);
         end
         if (cmd.acc) begin
            sa_ff <= (48'(pa_ff >> 16) > SUM_MAX - sa_ff) ? SUM_MAX : sa_ff + 48'(pa_ff >> 16);
            sb_ff <= (48'(pb_ff >> 16) > SUM_MAX - sb_ff) ? SUM_MAX : sb_ff + 48'(pb_ff >> 16);
         end
         if (cmd.rd) rix_ff <= rix_ff + 1'b1;
      end
   end

   // divider
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         dc_ff <= '0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
         dc_ff <= '0;
         ra_ff <= '0;
         rb_ff <= '0;
         qa_ff <= '0;
         qb_ff <= '0;
         case (cmd.sel)
            DIV_MEAN: begin
               dna_ff <= 64'(ea[32] ? -ea : ea);
               dnb_ff <= 64'(eb[32] ? -eb : eb);
               dvra_ff <= 32'(cnt_ff);
               dvrb_ff <= 32'(cnt_ff);
            end
            DIV_VAR: begin
               dna_ff <= {sa_ff, 16'd0};
               dnb_ff <= {sb_ff, 16'd0};
               dvra_ff <= 32'(cnt_ff);
               dvrb_ff <= 32'(cnt_ff);
            end
            default: begin
               dna_ff <= 64'(na[32] ? -na : na) << 12;
               dnb_ff <= 64'(nb[32] ? -nb : nb) << 12;
               dvra_ff <= (stda_ff == 0) ? 32'd1 : stda_ff;
               dvrb_ff <= (stdb_ff == 0) ? 32'd1 : stdb_ff;
            end
         endcase
      end else if (dbusy_ff) begin
         ra_ff <= tra[64] ? {ra_ff[62:0], dna_ff[63]} : tra[63:0];
         rb_ff <= trb[64] ? {rb_ff[62:0], dnb_ff[63]} : trb[63:0];
         qa_ff <= {qa_ff[62:0], ~tra[64]};
         qb_ff <= {qb_ff[62:0], ~trb[64]};
         dna_ff <= dna_ff << 1;
         dnb_ff <= dnb_ff << 1;
         dc_ff <= dc_ff + 1'b1;
         if (dc_ff == 7'd63) dbusy_ff <= 1'b0;
      end
   end

   logic dbusy_q;
   always_ff @(posedge clock) begin
      if (reset) dbusy_q <= 1'b0;
      else dbusy_q <= dbusy_ff;
   end
   assign sts.div_done = dbusy_q && !dbusy_ff;

   // root
   logic [63:0] sa_t, sb_t;
   assign sa_t = rta_ff + bit_ff;
   assign sb_t = rtb_ff + bit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
      end else if (cmd.sqrt_start) begin
         sbusy_ff <= 1'b1;
         va_ff <= qa_ff;
         vb_ff <= qb_ff;
         rta_ff <= '0;
         rtb_ff <= '0;
         bit_ff <= 64'd1 << 62;
      end else if (sbusy_ff) begin
         if (va_ff >= sa_t) begin
            va_ff <= va_ff - sa_t;
            rta_ff <= (rta_ff >> 1) + bit_ff;
         end else rta_ff <= rta_ff >> 1;
         if (vb_ff >= sb_t) begin
            vb_ff <= vb_ff - sb_t;
            rtb_ff <= (rtb_ff >> 1) + bit_ff;
         end else rtb_ff <= rtb_ff >> 1;
         bit_ff <= bit_ff >> 2;
         if (bit_ff == 64'd1) sbusy_ff <= 1'b0;
      end
   end
   logic sbusy_q;
   always_ff @(posedge clock) begin
      if (reset) sbusy_q <= 1'b0;
      else sbusy_q <= sbusy_ff;
      if (sbusy_q && !sbusy_ff) begin
         stda_ff <= rta_ff[31:0];
         stdb_ff <= rtb_ff[31:0];
      end
   end
   assign sts.sqrt_done = sbusy_q && !sbusy_ff;

   // output formatting
   logic neg_a, neg_b;
   logic [IDX_W-1:0] oix_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_start && cmd.sel == DIV_NORM) begin
         neg_a <= na[32];
         neg_b <= nb[32];
         oix_ff <= rix_ff - 1'b1;
      end
   end
   always_comb begin
      if (stda_ff == 0) norm_a = '0;
      else if (neg_a) norm_a = (qa_ff > 64'd32768) ? 16'sh8000 : 16'(-qa_ff);
      else norm_a = (qa_ff > 64'd32767) ? 16'sh7FFF : 16'(qa_ff);
      if (stdb_ff == 0) norm_b = '0;
      else if (neg_b) norm_b = (qb_ff > 64'd32768) ? 16'sh8000 : 16'(-qb_ff);
      else norm_b = (qb_ff > 64'd32767) ? 16'sh7FFF : 16'(qb_ff);
   end
   assign idx = oix_ff;
   assign dev_a = (stda_ff[31:8] > 24'hFFFF) ? 16'hFFFF : stda_ff[23:8];
   assign zs = {stdb_ff == 0, stda_ff == 0};
   assign ovf = drop_ff;
   assign sts.full = cnt_ff == CNT_W'(MAX_SAMPLES);
   assign sts.fin = fin_ff;
   assign sts.empty = cnt_ff == '0;
   assign sts.last = CNT_W'(oix_ff) + 1'b1 == cnt_ff;
endmodule

@@ hdl/wzn_control.sv @@
// wzn_control: sequencer for load, deviation and output phases
// depends on wzn_pkg
`timescale 1ns / 1ps
module wzn_control import wzn_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type st_ff, st_in;
   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end
   always_comb begin
      st_in = st_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               st_in = ST_LD_DIV;
            end
         end
         ST_LD_DIV: begin
            if (!sts.full) begin
               cmd.store_wr = 1'b1;
               st_in = ST_LD_MUL;
            end else if (sts.fin) st_in = sts.empty ? ST_IDLE : ST_SD_DIV;
            else st_in = ST_IDLE;
         end
         ST_LD_MUL: begin
            // deviation against old mean latched; start mean step
            cmd.div_start = 1'b1;
            cmd.sel = DIV_MEAN;
            st_in = ST_LD_WAIT;
         end
         ST_LD_WAIT: begin
            // new mean lands on the done cycle
            if (sts.div_done) st_in = ST_LD_PROD;
         end
         ST_LD_PROD: begin
            cmd.mul_step = 1'b1;
            st_in = ST_LD_ACC;
         end
         ST_LD_ACC: begin
            cmd.acc = 1'b1;
            st_in = sts.fin ? ST_SD_DIV : ST_IDLE;
         end
         ST_SD_DIV: begin
            cmd.div_start = 1'b1;
            cmd.sel = DIV_VAR;
            st_in = ST_SD_SQRT;
         end
         ST_SD_SQRT: begin
            if (sts.div_done) cmd.sqrt_start = 1'b1;
            if (sts.sqrt_done) begin
               cmd.rd = 1'b1;
               st_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.div_start = 1'b1;
            cmd.sel = DIV_NORM;
            st_in = ST_NM_DIV;
         end
         ST_NM_DIV: begin
            if (sts.div_done) st_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sts.last) begin
                  cmd.clr = 1'b1;
                  st_in = ST_IDLE;
               end else begin
                  cmd.rd = 1'b1;
                  st_in = ST_RD;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end
endmodule
